FILE: sv/dtg_pkg.sv
// Package for the grouped decimal text block.
// Holds the character codes, the result item type and the state encodings.
// No dependencies.
`default_nettype none
package dtg_pkg;

  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [7:0] SEP_CHAR  = 8'h5F;
  localparam int unsigned GROUP    = 3;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } dtg_char_t;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } top_state_e;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SKIP,
    E_DIG,
    E_SEP
  } emit_state_e;

endpackage
`default_nettype wire

FILE: sv/dtg_dabble.sv
// Binary to BCD converter: one shift-and-add-3 step per cycle.
// Shifts in every bit of the value, MSB first. Depends on nothing but its parameters.
`default_nettype none
module dtg_dabble #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned DIGITS     = 10
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [VALUE_BITS-1:0]   value_i,
  output logic                         done_o,
  output logic [4*DIGITS-1:0]          bcd_o
);

  localparam int unsigned DW = 4 * DIGITS;
  localparam int unsigned CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin_q;
  logic [DW-1:0]         bcd_q;
  logic [DW-1:0]         adj;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic                  done_q;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(VALUE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bcd_q <= {adj[DW-2:0], bin_q[VALUE_BITS-1]};
      bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule
`default_nettype wire

FILE: sv/dtg_emit.sv
// Character sequencer: skips leading zero digits, then sends one digit or
// separator per cycle through an output register, unless the output stalls. Depends on dtg_pkg.
`default_nettype none
module dtg_emit
  import dtg_pkg::*;
#(
  parameter int unsigned DIGITS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic [4*DIGITS-1:0]  bcd_i,
  output logic                      busy_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output dtg_char_t                 item_o
);

  localparam int unsigned DW = 4 * DIGITS;
  localparam int unsigned LW = $clog2(DIGITS);
  localparam logic [LW-1:0] LEFT_INIT = LW'(DIGITS - 1);
  localparam logic [1:0]    GRP_INIT  = 2'((DIGITS - 1) % GROUP);

  emit_state_e   state_q, state_d;
  logic [DW-1:0] dig_q, dig_d;
  logic [LW-1:0] left_q, left_d;
  logic [1:0]    grp_q, grp_d;
  logic          ov_q, ov_d;
  dtg_char_t     item_q, item_d;
  logic [3:0]    top_dig;
  logic          slot_free;

  assign top_dig   = dig_q[DW-1 -: 4];
  assign slot_free = !ov_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    left_q <= left_d;
    grp_q  <= grp_d;
    item_q <= item_d;
  end

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    left_d  = left_q;
    grp_d   = grp_q;
    item_d  = item_q;
    ov_d    = ov_q && !ready_i;
    unique case (state_q)
      E_IDLE: begin
        if (load_i) begin
          dig_d   = bcd_i;
          left_d  = LEFT_INIT;
          grp_d   = GRP_INIT;
          state_d = E_SKIP;
        end
      end
      E_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_dig == 4'd0 && left_q != '0) begin
          dig_d  = {dig_q[DW-5:0], 4'd0};
          left_d = left_q - 1'b1;
          grp_d  = (grp_q == 2'd0) ? 2'd2 : grp_q - 2'd1;
        end else begin
          state_d = E_DIG;
        end
      end
      E_DIG: begin
        if (slot_free) begin
          ov_d             = 1'b1;
          item_d.character = ZERO_CHAR + {4'd0, top_dig};
          item_d.last      = (left_q == '0);
          if (left_q == '0) begin
            state_d = E_IDLE;
          end else begin
            dig_d   = {dig_q[DW-5:0], 4'd0};
            left_d  = left_q - 1'b1;
            grp_d   = (grp_q == 2'd0) ? 2'd2 : grp_q - 2'd1;
            state_d = (grp_q == 2'd0) ? E_SEP : E_DIG;
          end
        end
      end
      E_SEP: begin
        if (slot_free) begin
          ov_d             = 1'b1;
          item_d.character = SEP_CHAR;
          item_d.last      = 1'b0;
          state_d          = E_DIG;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  assign busy_o  = (state_q != E_IDLE);
  assign valid_o = ov_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

FILE: sv/decimal_text_with_digit_grouping.sv
// Grouped decimal text: one unsigned value in, its ASCII digits out, MSD first,
// with '_' between groups of three. The converter works bit-serially and the
// sequencer then sends one character per cycle while the output is not stalled.
// A new value is accepted only while neither the converter nor the sequencer
// is busy. Reset clears all control state; no clearing pass.
`default_nettype none
module decimal_text_with_digit_grouping
  import dtg_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata_i,   // value
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [7:0]                             m_axis_tdata_o,   // character
  output logic                                   m_axis_tlast_o
);

  localparam int unsigned DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

  top_state_e          state_q, state_d;
  logic                accept;
  logic                conv_done;
  logic [4*DIGITS-1:0] bcd;
  logic                emit_busy;
  dtg_char_t           item;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !emit_busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CONV;
      ST_CONV: if (conv_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  dtg_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (s_axis_tdata_i[VALUE_BITS-1:0]),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  dtg_emit #(
    .DIGITS (DIGITS)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (conv_done),
    .bcd_i   (bcd),
    .busy_o  (emit_busy),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .item_o  (item)
  );

  assign m_axis_tdata_o = item.character;
  assign m_axis_tlast_o = item.last;

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o != SEP_CHAR)
    else $error("final character is a separator");

  a_conv_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> !emit_busy)
    else $error("sequencer busy during conversion");

endmodule
`default_nettype wire

FILE: bench/decimal_text_with_digit_grouping_tb.sv
`timescale 1ns / 100ps
// Testbench for decimal_text_with_digit_grouping: sends unsigned values, predicts the
// grouped ASCII text of each and checks every character and its last flag in order.
// Depends on dtg_pkg and the block's RTL.
module decimal_text_with_digit_grouping_tb;
  import dtg_pkg::*;

  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          DRAIN_WAIT = 80;
  localparam int          RANDOM_ITEMS = 76;

  class text_scoreboard;
    dtg_char_t expected_q[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %0s", $time, msg);
      errors++;
    endtask

    // Render the value as decimal text, MSD first, '_' ahead of each group of three.
    function void note_value(input logic [VALUE_BITS-1:0] value);
      int unsigned rest;
      logic [3:0]  digs[MAX_DIGITS];
      int          n;
      int          left;
      int          i;
      dtg_char_t   c;
      rest = 32'(value);
      n = 0;
      do begin
        digs[n] = 4'(rest % 10);
        rest = rest / 10;
        n++;
      end while (rest != 0);
      for (i = 0; i < n; i++) begin
        left = n - 1 - i;
        c.character = ZERO_CHAR + {4'b0, digs[left]};
        c.last      = (left == 0);
        expected_q.push_back(c);
        if (left > 0 && (left % GROUP) == 0) begin
          c.character = SEP_CHAR;
          c.last      = 1'b0;
          expected_q.push_back(c);
        end
      end
    endfunction

    task check_char(input logic [7:0] character, input logic last);
      dtg_char_t exp_c;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last=%0b", character, last));
      end else begin
        exp_c = expected_q.pop_front();
        if (character !== exp_c.character)
          report($sformatf("character 0x%02h, expected 0x%02h", character, exp_c.character));
        if (last !== exp_c.last)
          report($sformatf("last %0b, expected %0b", last, exp_c.last));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              m_tready = 1'b0;
  wire               s_tready;
  wire               m_tvalid;
  wire [7:0]         m_tdata;
  wire               m_tlast;

  text_scoreboard sb = new();
  int idle_cycles = 0;
  int rx_left = 0;
  int rx_mode = 0;
  int burst_left = 0;

  decimal_text_with_digit_grouping #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // value
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),   // character
    .m_axis_tlast_o (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note accepted values and check accepted characters on pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready)
      sb.note_value(s_tdata[VALUE_BITS-1:0]);
    if (rst_ni && m_tvalid && m_tready)
      sb.check_char(m_tdata, m_tlast);
  end

  // Receiver: segments of always-ready, full stall or coin-flip ready.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_left <= $urandom_range(1, 16);
      rx_mode <= ($urandom_range(0, 3) < 2) ? 0 : $urandom_range(1, 2);
      m_tready <= 1'b1;
    end else begin
      rx_left <= rx_left - 1;
      case (rx_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'b0;
        end
        default: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
      endcase
    end
  end

  // End the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task send_value(input logic [VALUE_BITS-1:0] value);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(DATA_W - VALUE_BITS){1'b0}}, value};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Advance one edge first so the last accepted value is noted before the check.
  task wait_drained();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned bits;
    int unsigned p10;
    int unsigned k;
    if ($urandom_range(0, 3) == 0) begin
      // land next to a power of ten, where the digit count changes
      p10 = 1;
      k = $urandom_range(1, 9);
      repeat (k) p10 = p10 * 10;
      return VALUE_BITS'(p10 - 1 + $urandom_range(0, 2));
    end
    bits = $urandom_range(1, VALUE_BITS);
    return VALUE_BITS'($urandom & ((32'h1 << bits) - 1));
  endfunction

  logic [VALUE_BITS-1:0] directed_q[$] = '{
    0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 99999, 100000, 999999, 1000000,
    9999999, 10000000, 99999999, 100000000, 999999999, 1000000000, 1234567890,
    31'h2AAA_AAAA, 31'h5555_5555, 31'h7FFF_FFFF
  };

  initial begin
    int i;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[j])
      send_value(directed_q[j]);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // hold off until the block has emitted everything it owes
        s_tvalid <= 1'b0;
        wait_drained();
      end
      send_value(random_value());
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
